### hdl/slrd_pkg.sv
// Package of constants, types and helper functions for the scroll and LED register device.
`default_nettype none

package slrd_pkg;

	// Register file geometry and special register addresses.
	localparam int REG_COUNT = 8;
	localparam int IDX_W = $clog2(REG_COUNT);
	localparam logic [8:0] ADDR_LIMIT = 9'(REG_COUNT);
	localparam logic [7:0] LED_REG = 8'd0;
	localparam logic [7:0] WHITE_REG = 8'd1;
	localparam logic [7:0] CLICKS_REG = 8'd2;

	// Click counter centre and clamp limits.
	localparam logic [7:0] CLICK_CENTRE = 8'h80;
	localparam logic [7:0] CLICK_HIGH = 8'd132;
	localparam logic [7:0] CLICK_HIGH_CLAMP = 8'd129;
	localparam logic [7:0] CLICK_LOW = 8'd124;
	localparam logic [7:0] CLICK_LOW_CLAMP = 8'd127;
	localparam logic [7:0] LEVEL_FULL = 8'd255;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_HOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 2'd2;
	localparam logic [15:0] FULL_HOLD_RESET = 16'd4000;
	localparam logic [15:0] EXTEND_HOLD_RESET = 16'd5000;
	localparam logic [7:0] STEP_PERIOD_RESET = 8'd8;

	// Item kinds carried in the input tuser field.
	typedef enum logic [2:0] {
		FUNC_SELECT = 3'd0,
		FUNC_WRITE  = 3'd1,
		FUNC_READ   = 3'd2,
		FUNC_TICK   = 3'd3,
		FUNC_SCROLL = 3'd4
	} func_t;

	// Value that a register entry holds after reset.
	function automatic logic [7:0] entry_reset(input logic [IDX_W-1:0] idx);
		logic [7:0] v;
		v = 8'd0;
		if ({{(9-IDX_W){1'b0}}, idx} == {1'b0, CLICKS_REG}) begin
			v = CLICK_CENTRE;
		end
		return v;
	endfunction

	// True when an address falls inside the register file.
	function automatic logic in_file(input logic [7:0] addr);
		return {1'b0, addr} < ADDR_LIMIT;
	endfunction

endpackage

`default_nettype wire

### hdl/scroll_led_register_device_top.sv
// Top level of the scroll and LED register device: register file memory, pointer and fade logic.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tuser func, tdata reg_addr, wdata, step_up
//  m_*     | out       | m_tvalid/m_tready  | tdata read_data, leds, pwm_level, scroll_irq
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_addr register index, cfg_data value
//
// The register file is read at the accept edge and the read-modify-write happens in the middle
// stage, whose result is loaded into the output register when the stage moves on. One item is
// accepted every cycle while the middle stage is empty or moving on: the memory reads at the
// accept edge and writes at the retire edge through separate ports, with forwarding from the
// write of the item just ahead.
// Reset is asynchronous and clears all control state and the per-entry valid bits, so the
// register file reads its reset contents at once without a clearing pass.
// A stalled output holds its item; the input keeps accepting while the output register or the
// middle stage has room.
`default_nettype none

module scroll_led_register_device_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // reg_addr[7:0], wdata[15:8], step_up[16], zero fill
	input  wire logic [2:0]  s_tuser,  // func[2:0]
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // read_data[7:0], red_led[8], green_led[9],
	                                   // orange_led[10], pwm_level[18:11], scroll_irq[19],
	                                   // zero fill
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_data
);

	localparam int IW = slrd_pkg::IDX_W;
	localparam int RC = slrd_pkg::REG_COUNT;

	// Configuration registers.
	logic [15:0] full_hold_q;
	logic [15:0] extend_hold_q;
	logic [7:0]  step_period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_hold_q   <= slrd_pkg::FULL_HOLD_RESET;
			extend_hold_q <= slrd_pkg::EXTEND_HOLD_RESET;
			step_period_q <= slrd_pkg::STEP_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				slrd_pkg::CFG_FULL_HOLD:   full_hold_q   <= cfg_data;
				slrd_pkg::CFG_EXTEND_HOLD: extend_hold_q <= cfg_data;
				slrd_pkg::CFG_STEP_PERIOD: step_period_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input fields.
	slrd_pkg::func_t in_func;
	logic [7:0] in_addr;
	logic [7:0] in_wdata;
	logic       in_up;

	assign in_func  = slrd_pkg::func_t'(s_tuser[2:0]);
	assign in_addr  = s_tdata[7:0];
	assign in_wdata = s_tdata[15:8];
	assign in_up    = s_tdata[16];

	// Stage handshake. The middle stage moves on when the output register is free or
	// drained in this cycle; a new item enters whenever the middle stage is empty or moving.
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic accept;

	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// Pointer and the armed clicks read depend only on the item itself, so they are kept
	// at the accept stage, where they also choose the memory read address.
	logic [7:0] ptr_q;
	logic       armed_q;
	logic [8:0] ptr_inc;
	logic [7:0] ptr_next;
	logic [7:0] rd_addr;

	assign ptr_inc  = {1'b0, ptr_q} + 9'd1;
	assign ptr_next = (ptr_inc >= slrd_pkg::ADDR_LIMIT) ? 8'd0 : ptr_inc[7:0];

	always_comb begin
		unique case (in_func)
			slrd_pkg::FUNC_READ:   rd_addr = armed_q ? slrd_pkg::CLICKS_REG : ptr_q;
			slrd_pkg::FUNC_TICK:   rd_addr = slrd_pkg::WHITE_REG;
			slrd_pkg::FUNC_SCROLL: rd_addr = slrd_pkg::CLICKS_REG;
			default:               rd_addr = ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= 8'd0;
			armed_q <= 1'b0;
		end else if (accept) begin
			unique case (in_func)
				slrd_pkg::FUNC_SELECT, slrd_pkg::FUNC_WRITE: begin
					ptr_q <= in_addr;
					if (in_addr == slrd_pkg::CLICKS_REG) begin
						armed_q <= 1'b1;
					end
				end
				slrd_pkg::FUNC_READ: begin
					ptr_q   <= ptr_next;
					armed_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Register file memory and the valid bits that stand for its reset contents.
	logic [7:0]    mem [RC];
	logic [RC-1:0] entry_vld_q;
	logic          mem_we;
	logic [7:0]    mem_waddr;
	logic [7:0]    mem_wdata;
	logic [IW-1:0] mem_widx;
	logic [IW-1:0] rd_idx;
	logic          rd_ok;

	assign mem_widx = mem_waddr[IW-1:0];
	assign rd_idx   = rd_addr[IW-1:0];
	assign rd_ok    = slrd_pkg::in_file(rd_addr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_widx] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (mem_we) begin
			entry_vld_q[mem_widx] <= 1'b1;
		end
	end

	// Middle stage: the item, its registered read data and the write that was retired at
	// the same edge, which the memory read could not yet see.
	slrd_pkg::func_t func_s1;
	logic [7:0]    addr_s1;
	logic [7:0]    wdata_s1;
	logic          up_s1;
	logic          armed_s1;
	logic          rd_ok_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [7:0]    rdata_s1;
	logic          rd_vld_s1;
	logic          fwd_en_s1;
	logic [IW-1:0] fwd_idx_s1;
	logic [7:0]    fwd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= in_func;
			addr_s1     <= in_addr;
			wdata_s1    <= in_wdata;
			up_s1       <= in_up;
			armed_s1    <= armed_q;
			rd_ok_s1    <= rd_ok;
			rd_idx_s1   <= rd_idx;
			rd_vld_s1   <= rd_ok ? entry_vld_q[rd_idx] : 1'b0;
			fwd_en_s1   <= mem_we;
			fwd_idx_s1  <= mem_widx;
			fwd_data_s1 <= mem_wdata;
			if (rd_ok) begin
				rdata_s1 <= mem[rd_idx];
			end
		end
	end

	// Entry value as the item sees it, or zero for an address outside the file.
	logic [7:0] cur;

	always_comb begin
		priority if (!rd_ok_s1) begin
			cur = 8'd0;
		end else if (fwd_en_s1 && fwd_idx_s1 == rd_idx_s1) begin
			cur = fwd_data_s1;
		end else if (rd_vld_s1) begin
			cur = rdata_s1;
		end else begin
			cur = slrd_pkg::entry_reset(rd_idx_s1);
		end
	end

	// Time, fade and hold state. time_p1_q always holds time_q plus one, which keeps the
	// tick path to one wide add and compare.
	logic [31:0] time_q;
	logic [31:0] time_p1_q;
	logic [31:0] hold_q;
	logic [7:0]  step_timer_q;
	logic [7:0]  level_q;
	logic [2:0]  led_q;

	// Next values from the middle stage.
	logic [31:0] hold_d;
	logic [7:0]  step_timer_d;
	logic [7:0]  level_d;
	logic [7:0]  rdata_d;
	logic        irq_d;
	logic        tick_d;
	logic [7:0]  period;
	logic [8:0]  timer_inc;
	logic        fire;
	logic [7:0]  click;

	assign period    = (step_period_q == 8'd0) ? 8'd1 : step_period_q;
	assign timer_inc = {1'b0, step_timer_q} + 9'd1;
	assign fire      = timer_inc >= {1'b0, period};
	assign click     = up_s1 ? cur + 8'd1 : cur - 8'd1;

	always_comb begin
		hold_d       = hold_q;
		step_timer_d = step_timer_q;
		level_d      = level_q;
		rdata_d      = 8'd0;
		irq_d        = 1'b0;
		tick_d       = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = addr_s1;
		mem_wdata    = wdata_s1;
		unique case (func_s1)
			slrd_pkg::FUNC_WRITE: begin
				// Writes to the clicks address only arm the read.
				if (addr_s1 != slrd_pkg::CLICKS_REG && slrd_pkg::in_file(addr_s1)) begin
					mem_we = 1'b1;
					if (addr_s1 == slrd_pkg::WHITE_REG && hold_q > time_q) begin
						hold_d = time_q + {16'd0, extend_hold_q};
					end
				end
			end
			slrd_pkg::FUNC_READ: begin
				rdata_d = cur;
				if (armed_s1 && slrd_pkg::in_file(slrd_pkg::CLICKS_REG)) begin
					mem_we    = 1'b1;
					mem_waddr = slrd_pkg::CLICKS_REG;
					mem_wdata = slrd_pkg::CLICK_CENTRE;
				end
			end
			slrd_pkg::FUNC_TICK: begin
				tick_d       = 1'b1;
				step_timer_d = fire ? 8'd0 : timer_inc[7:0];
				if (cur != level_q) begin
					if (fire) begin
						level_d = (cur > level_q) ? level_q + 8'd1 : level_q - 8'd1;
						if (level_d == slrd_pkg::LEVEL_FULL) begin
							hold_d = time_p1_q + {16'd0, full_hold_q};
						end
					end
				end else if (cur == slrd_pkg::LEVEL_FULL && time_p1_q > hold_q) begin
					// The hold has run out: the target falls to zero.
					mem_we    = 1'b1;
					mem_waddr = slrd_pkg::WHITE_REG;
					mem_wdata = 8'd0;
				end
			end
			slrd_pkg::FUNC_SCROLL: begin
				mem_waddr = slrd_pkg::CLICKS_REG;
				mem_we    = slrd_pkg::in_file(slrd_pkg::CLICKS_REG);
				priority if (click > slrd_pkg::CLICK_HIGH) begin
					mem_wdata = slrd_pkg::CLICK_HIGH_CLAMP;
					irq_d     = 1'b1;
				end else if (click < slrd_pkg::CLICK_LOW) begin
					mem_wdata = slrd_pkg::CLICK_LOW_CLAMP;
					irq_d     = 1'b1;
				end else begin
					mem_wdata = click;
				end
			end
			default: ;
		endcase
		// Nothing retires unless the stage moves on.
		mem_we = mem_we && s1_adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q       <= 32'd0;
			time_p1_q    <= 32'd1;
			hold_q       <= 32'd0;
			step_timer_q <= 8'd0;
			level_q      <= 8'd0;
			led_q        <= 3'd0;
		end else if (s1_adv) begin
			hold_q       <= hold_d;
			step_timer_q <= step_timer_d;
			level_q      <= level_d;
			if (tick_d) begin
				time_q    <= time_p1_q;
				time_p1_q <= time_p1_q + 32'd1;
			end
			// Shadow of the LED bits, following every store to the LED entry.
			if (mem_we && mem_waddr == slrd_pkg::LED_REG) begin
				led_q <= mem_wdata[2:0];
			end
		end
	end

	// Output register. The LED and level state only change when a new item is loaded here,
	// so while an item waits they still show the state that item left.
	logic [7:0] out_rdata_q;
	logic       out_irq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_rdata_q <= rdata_d;
			out_irq_q   <= irq_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_irq_q, level_q, led_q[2], led_q[1], led_q[0], out_rdata_q};

`ifndef NO_ASSERTIONS
	// The input only stalls when both stages are full and the output is held.
	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

	// The register file is only written by an item that leaves the middle stage.
	a_write_retires: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> s1_adv)
		else $error("register file written by a stalled item");

	// After a read the pointer lies inside the register file.
	a_ptr_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_func == slrd_pkg::FUNC_READ) |=> slrd_pkg::in_file(ptr_q))
		else $error("pointer left the register file after a read");

	// The white level moves by at most one step per item.
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q != $past(level_q)) |->
			(level_q == $past(level_q) + 8'd1 || level_q == $past(level_q) - 8'd1))
		else $error("white level jumped by more than one step");
`endif

endmodule

`default_nettype wire
